// File: src/a2icb_pkg.sv
package a2icb_pkg;

  localparam int unsigned MAX_ALPHABET_DEF = 16;

  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned CFG_W    = 64;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned LEN_W    = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_LEN  = 2'd2;

  localparam logic [CFG_W-1:0] ALPHA_LOW_RST  = 64'h3736_3534_3332_3130;
  localparam logic [CFG_W-1:0] ALPHA_HIGH_RST = 64'h0000_0000_0000_3938;
  localparam logic [LEN_W-1:0] ALPHA_LEN_RST  = 5'd10;

  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0d;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2b;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;

  typedef enum logic [3:0] {
    PH_SKIP  = 4'b0001,
    PH_SIGN  = 4'b0010,
    PH_DIGIT = 4'b0100,
    PH_STOP  = 4'b1000
  } phase_t;

endpackage

// File: src/a2icb_if.sv
interface a2icb_in_if;
  logic                            valid;
  logic                            ready;
  logic [a2icb_pkg::CHAR_W-1:0]    character;
  logic                            final_char;

  modport source (output valid, output character, output final_char, input ready);
  modport sink   (input valid, input character, input final_char, output ready);
endinterface

interface a2icb_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [a2icb_pkg::VALUE_W-1:0] value;
  logic                                alphabet_ok;

  modport source (output valid, output value, output alphabet_ok, input ready);
  modport sink   (input valid, input value, input alphabet_ok, output ready);
endinterface

// File: src/ascii_to_int_custom_base_core.sv
// Streaming text-to-integer converter with a configurable digit alphabet of up to
// MAX_ALPHABET symbols. One character word enters per cycle unless stalled; a
// word goes into an input register, and from there the whitespace/sign/digit
// state, the alphabet lookup (parallel compare) and the 32-bit multiply-add by
// the radix are done in one pass into the state and the result register, so
// the block sustains one character per cycle unless stalled, and a result is
// registered when the final character leaves the input register. The result
// register decouples the sides: the block stalls only while a result is still
// waiting and the next final character sits in the input register.
// Alphabet registers may be written only while no string is in flight.
module ascii_to_int_custom_base_core #(
  parameter int unsigned MAX_ALPHABET = a2icb_pkg::MAX_ALPHABET_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  a2icb_in_if.sink                          in_ch,
  a2icb_out_if.source                       out_ch,
  input  logic                              cfg_we,
  input  logic [a2icb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [a2icb_pkg::CFG_W-1:0]       cfg_wdata
);

  localparam int unsigned RADIX_W = $clog2(MAX_ALPHABET + 1);
  localparam int unsigned IDX_W   = $clog2(MAX_ALPHABET);
  localparam int unsigned CW      = a2icb_pkg::CHAR_W;
  localparam int unsigned VW      = a2icb_pkg::VALUE_W;

  // configuration
  logic [a2icb_pkg::CFG_W-1:0] alpha_lo_r;
  logic [a2icb_pkg::CFG_W-1:0] alpha_hi_r;
  logic [a2icb_pkg::LEN_W-1:0] alpha_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_lo_r  <= a2icb_pkg::ALPHA_LOW_RST;
      alpha_hi_r  <= a2icb_pkg::ALPHA_HIGH_RST;
      alpha_len_r <= a2icb_pkg::ALPHA_LEN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        a2icb_pkg::CFG_ALPHA_LOW:  alpha_lo_r  <= cfg_wdata;
        a2icb_pkg::CFG_ALPHA_HIGH: alpha_hi_r  <= cfg_wdata;
        a2icb_pkg::CFG_ALPHA_LEN:  alpha_len_r <= cfg_wdata[a2icb_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  logic          in_valid_r;
  logic [CW-1:0] in_char_r;
  logic          in_final_r;
  logic          advance;

  assign in_ch.ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_char_r  <= in_ch.character;
      in_final_r <= in_ch.final_char;
    end
  end

  // alphabet decode
  logic [RADIX_W-1:0]              radix;
  logic [2*a2icb_pkg::CFG_W-1:0]   alpha_all;
  logic [CW-1:0]                   sym [MAX_ALPHABET];
  logic [MAX_ALPHABET-1:0]         in_use;
  logic                            alpha_ok;
  logic                            hit;
  logic [IDX_W-1:0]                digit;

  assign alpha_all = {alpha_hi_r, alpha_lo_r};
  assign radix = (alpha_len_r > a2icb_pkg::LEN_W'(MAX_ALPHABET)) ?
                 RADIX_W'(MAX_ALPHABET) : alpha_len_r[RADIX_W-1:0];

  always_comb begin
    for (int k = 0; k < MAX_ALPHABET; k++) begin
      sym[k]    = alpha_all[k*CW +: CW];
      in_use[k] = RADIX_W'(k) < radix;
    end
  end

  always_comb begin
    alpha_ok = 1'b1;
    for (int i = 0; i < MAX_ALPHABET; i++) begin
      if (in_use[i] && (sym[i] == a2icb_pkg::CH_PLUS || sym[i] == a2icb_pkg::CH_MINUS)) begin
        alpha_ok = 1'b0;
      end
      for (int j = i + 1; j < MAX_ALPHABET; j++) begin
        if (in_use[j] && sym[j] == sym[i]) begin
          alpha_ok = 1'b0;
        end
      end
    end
  end

  // lowest matching symbol wins
  always_comb begin
    hit   = 1'b0;
    digit = '0;
    for (int k = MAX_ALPHABET - 1; k >= 0; k--) begin
      if (in_use[k] && sym[k] == in_char_r) begin
        hit   = 1'b1;
        digit = IDX_W'(k);
      end
    end
  end

  // conversion state
  a2icb_pkg::phase_t phase_r, phase_nxt;
  logic              neg_r, neg_nxt;
  logic [VW-1:0]     acc_r, acc_nxt;
  logic              is_ws;
  logic              is_sign;
  logic              in_sign;
  logic              in_digit;
  logic [VW-1:0]     mac;

  assign is_ws = (in_char_r == a2icb_pkg::CH_SPACE) ||
                 (in_char_r >= a2icb_pkg::CH_TAB && in_char_r <= a2icb_pkg::CH_CR);
  assign is_sign = (in_char_r == a2icb_pkg::CH_PLUS) || (in_char_r == a2icb_pkg::CH_MINUS);
  assign in_sign = ((phase_r == a2icb_pkg::PH_SKIP) && !is_ws) ||
                   (phase_r == a2icb_pkg::PH_SIGN);
  assign in_digit = (in_sign && !is_sign) || (phase_r == a2icb_pkg::PH_DIGIT);
  assign mac = acc_r * VW'(radix) + VW'(digit);

  always_comb begin
    phase_nxt = phase_r;
    neg_nxt   = neg_r;
    acc_nxt   = acc_r;
    if (in_sign && is_sign) begin
      phase_nxt = a2icb_pkg::PH_SIGN;
      neg_nxt   = neg_r ^ (in_char_r == a2icb_pkg::CH_MINUS);
    end else if (in_digit) begin
      if (hit) begin
        phase_nxt = a2icb_pkg::PH_DIGIT;
        acc_nxt   = mac;
      end else begin
        phase_nxt = a2icb_pkg::PH_STOP;
      end
    end
  end

  // result register
  logic          out_valid_r;
  logic [VW-1:0] out_value_r;
  logic          out_ok_r;

  assign advance = in_valid_r && (!in_final_r || !out_valid_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= a2icb_pkg::PH_SKIP;
      neg_r   <= 1'b0;
      acc_r   <= '0;
    end else if (advance) begin
      if (in_final_r) begin
        phase_r <= a2icb_pkg::PH_SKIP;
        neg_r   <= 1'b0;
        acc_r   <= '0;
      end else begin
        phase_r <= phase_nxt;
        neg_r   <= neg_nxt;
        acc_r   <= acc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && in_final_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_final_r) begin
      out_ok_r <= alpha_ok;
      if (!alpha_ok) begin
        out_value_r <= '0;
      end else if (neg_nxt) begin
        out_value_r <= '0 - acc_nxt;
      end else begin
        out_value_r <= acc_nxt;
      end
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.value       = out_value_r;
  assign out_ch.alphabet_ok = out_ok_r;

endmodule
